// ===== design/dfbm_pkg.sv =====
package dfbm_pkg;

  localparam int unsigned OUT_COUNT_BITS = 16;
  localparam logic [7:0]  SPACE_CHAR     = 8'd32;

  typedef enum logic {
    OP_BODY,
    OP_END
  } op_kind_e;

  // one classified byte, front to back
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  // one finished frame summary
  typedef struct packed {
    logic [7:0]                mode_byte;
    logic [OUT_COUNT_BITS-1:0] mode_count;
    logic                      empty_frame;
  } res_t;

endpackage

// ===== design/dfbm_fifo.sv =====
module dfbm_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/dfbm_front.sv =====
module dfbm_front import dfbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       link_closed_i,
  output logic       op_push_o,
  output op_t        op_o,
  input  logic       op_full_i
);

  logic       in_body_q, in_body_d;
  logic [7:0] delim_q, delim_d;
  logic       accept;

  assign full   = op_full_i;
  assign accept = push && !op_full_i;

  always_comb begin
    in_body_d = in_body_q;
    delim_d   = delim_q;
    op_push_o = 1'b0;
    op_o.kind = OP_BODY;
    op_o.data = data_byte_i;
    if (accept) begin
      if (link_closed_i) begin
        // close while idle: nothing open, nothing to do
        if (in_body_q) begin
          op_push_o = 1'b1;
          op_o.kind = OP_END;
          in_body_d = 1'b0;
        end
      end else if (!in_body_q) begin
        delim_d   = data_byte_i;
        in_body_d = 1'b1;
      end else if (data_byte_i == delim_q) begin
        op_push_o = 1'b1;
        op_o.kind = OP_END;
        in_body_d = 1'b0;
      end else begin
        op_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      delim_q   <= '0;
    end else begin
      in_body_q <= in_body_d;
      delim_q   <= delim_d;
    end
  end

endmodule

// ===== design/dfbm_back.sv =====
module dfbm_back import dfbm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic op_empty_i,
  input  op_t  op_i,
  output logic op_pop_o,
  output logic res_push_o,
  output res_t res_o,
  input  logic res_full_i
);

  localparam int unsigned WB = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

  logic [COUNT_BITS-1:0] hist_mem [256];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [255:0]          valid_q, valid_d;

  logic                  ex_vld_q, ex_vld_d;
  op_t                   ex_op_q, ex_op_d;

  logic                  wr_vld_q, wr_vld_d;
  logic [7:0]            wr_addr_q, wr_addr_d;
  logic [COUNT_BITS-1:0] wr_data_q, wr_data_d;

  logic [7:0]            best_byte_q, best_byte_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;

  logic                  advance;
  logic                  hist_we;
  logic [COUNT_BITS-1:0] old_cnt, new_cnt;
  logic [WB-1:0]         best_wide;

  // only a frame end waiting on a full result queue stalls
  assign advance  = !(ex_vld_q && (ex_op_q.kind == OP_END) && res_full_i);
  assign op_pop_o = advance && !op_empty_i;

  // last write is not yet visible in rdata_q; cleared entries read as zero
  always_comb begin
    if (wr_vld_q && (wr_addr_q == ex_op_q.data)) begin
      old_cnt = wr_data_q;
    end else if (valid_q[ex_op_q.data]) begin
      old_cnt = rdata_q;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);
  end

  assign best_wide = WB'(best_cnt_q);

  always_comb begin
    res_o.mode_byte   = best_byte_q;
    res_o.mode_count  = (best_wide > WB'({OUT_COUNT_BITS{1'b1}})) ?
                        {OUT_COUNT_BITS{1'b1}} : best_wide[OUT_COUNT_BITS-1:0];
    res_o.empty_frame = (best_cnt_q == '0);
  end

  always_comb begin
    ex_vld_d    = ex_vld_q;
    ex_op_d     = ex_op_q;
    valid_d     = valid_q;
    wr_vld_d    = 1'b0;
    wr_addr_d   = ex_op_q.data;
    wr_data_d   = new_cnt;
    best_byte_d = best_byte_q;
    best_cnt_d  = best_cnt_q;
    hist_we     = 1'b0;
    res_push_o  = 1'b0;
    if (advance) begin
      ex_vld_d = !op_empty_i;
      ex_op_d  = op_i;
      if (ex_vld_q) begin
        case (ex_op_q.kind)
          OP_BODY: begin
            hist_we                = 1'b1;
            valid_d[ex_op_q.data]  = 1'b1;
            wr_vld_d               = 1'b1;
            if (new_cnt >= best_cnt_q) begin
              best_cnt_d  = new_cnt;
              best_byte_d = ex_op_q.data;
            end
          end
          OP_END: begin
            res_push_o  = 1'b1;
            valid_d     = '0;
            best_byte_d = SPACE_CHAR;
            best_cnt_d  = '0;
          end
          default: begin
            hist_we = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q    <= 1'b0;
      valid_q     <= '0;
      wr_vld_q    <= 1'b0;
      best_byte_q <= SPACE_CHAR;
      best_cnt_q  <= '0;
    end else begin
      ex_vld_q    <= ex_vld_d;
      valid_q     <= valid_d;
      wr_vld_q    <= wr_vld_d;
      best_byte_q <= best_byte_d;
      best_cnt_q  <= best_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_op_q   <= ex_op_d;
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
  end

  // histogram: read the queue head every cycle, write from execute
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[ex_op_q.data] <= new_cnt;
    end
    rdata_q <= hist_mem[op_i.data];
  end

endmodule

// ===== design/delimited_frame_byte_mode_top.sv =====
// Delimited-frame byte mode finder. Bytes enter through a queue-style port
// (push/full); the first byte after idle becomes the frame delimiter, body
// bytes are counted in a 256-entry histogram, and at the next delimiter or
// when link_closed is seen inside a frame one summary transaction comes out
// (empty/pop): the most frequent body byte (ties go to the byte seen most
// recently), its count clipped to 16 bits, and an empty flag (byte 32,
// count 0 for an empty frame). Throughput is one byte per cycle sustained
// while the result queue has room; it is set by the single histogram
// read-modify-write port, with the read issued from the head of a 4-entry
// op queue and the write forwarded into the next op. A frame end stalls the
// back end only while the 2-entry result queue is full. Histogram clear at
// frame end resets the per-entry valid bits; no clearing pass after reset.
module delimited_frame_byte_mode_top import dfbm_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        link_closed_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  mode_byte_o,
  output logic [15:0] mode_count_o,
  output logic        empty_frame_o
);

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  // front -> op queue
  logic op_push, op_full;
  op_t  op_in;
  // op queue -> back
  logic op_pop, op_empty;
  op_t  op_head;
  // back -> result queue
  logic res_push, res_full;
  res_t res_in, res_head;

  dfbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .link_closed_i (link_closed_i),
    .op_push_o     (op_push),
    .op_o          (op_in),
    .op_full_i     (op_full)
  );

  dfbm_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .wdata_i (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .rdata_o (op_head),
    .empty_o (op_empty)
  );

  dfbm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op_head),
    .op_pop_o   (op_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  dfbm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign mode_byte_o   = res_head.mode_byte;
  assign mode_count_o  = res_head.mode_count;
  assign empty_frame_o = res_head.empty_frame;

endmodule
